// File: hdl/tnc_pkg.sv
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared types, register indexes and wiring lookup functions for the
// three-rotor nibble cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package tnc_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 64;
    localparam int unsigned PosW     = 8;
    localparam int unsigned FifoDepth = 2;

    localparam logic [63:0] RotorIdentity  = 64'hFEDC_BA98_7654_3210;
    localparam logic [63:0] ReflectorReset = 64'h3849_60CE_2B1D_F75A;

    typedef logic [3:0]      t_nib;
    typedef logic [PosW-1:0] t_pos;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ROTOR_ONE   = 3'd0,
        REG_ROTOR_TWO   = 3'd1,
        REG_ROTOR_THREE = 3'd2,
        REG_REFLECTOR   = 3'd3,
        REG_FAST_START  = 3'd4,
        REG_MIDDLE_START = 3'd5,
        REG_SLOW_START  = 3'd6,
        REG_UNUSED      = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [63:0] rotor_one;
        logic [63:0] rotor_two;
        logic [63:0] rotor_three;
        logic [63:0] reflector;
    } t_wiring;

    typedef struct packed {
        logic load;
        t_pos fast;
        t_pos middle;
        t_pos slow;
    } t_start;

    // one word queued from front to back: symbol and the three offsets
    typedef struct packed {
        t_nib x;
        t_nib f;
        t_nib m;
        t_nib s;
    } t_job;

    function automatic t_nib nib_of(input logic [63:0] word, input t_nib idx);
        return word[{idx, 2'b00} +: 4];
    endfunction

    // lowest matching index, 0 when nothing matches
    function automatic t_nib inverse_of(input logic [63:0] word, input t_nib target);
        t_nib res;
        res = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (word[i*4 +: 4] == target) begin
                res = 4'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tnc_front.sv
// ----------------------------------------------------------------------------
// tnc_front
// Accepts input words, steps the selected rotor position set and hands the
// symbol with its offsets to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tnc_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire tnc_pkg::t_start i_start,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire                 i_command,
    input  wire tnc_pkg::t_nib  i_symbol_in,
    output logic                o_job_valid,
    output tnc_pkg::t_job       o_job,
    input  wire                 i_job_ready
);
    import tnc_pkg::*;

    t_pos r_enc_fast, r_enc_mid, r_enc_slow;
    t_pos r_dec_fast, r_dec_mid, r_dec_slow;
    t_pos n_fast, n_mid, n_slow;
    t_pos cur_fast, cur_mid, cur_slow;
    logic accept;

    assign o_ready     = i_job_ready;
    assign o_job_valid = i_valid;
    assign accept      = i_valid && i_job_ready;

    always_comb begin
        if (t_cmd'(i_command) == CMD_DECRYPT) begin
            cur_fast = r_dec_fast;
            cur_mid  = r_dec_mid;
            cur_slow = r_dec_slow;
        end else begin
            cur_fast = r_enc_fast;
            cur_mid  = r_enc_mid;
            cur_slow = r_enc_slow;
        end
        // odometer step with carries on wrap
        n_fast = cur_fast + 1'b1;
        n_mid  = (cur_fast == '1) ? cur_mid + 1'b1 : cur_mid;
        n_slow = (cur_fast == '1 && cur_mid == '1) ? cur_slow + 1'b1 : cur_slow;
        o_job.x = i_symbol_in;
        o_job.f = n_fast[3:0];
        o_job.m = n_mid[3:0];
        o_job.s = n_slow[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_fast <= '0;
            r_enc_mid  <= '0;
            r_enc_slow <= '0;
            r_dec_fast <= '0;
            r_dec_mid  <= '0;
            r_dec_slow <= '0;
        end else if (i_start.load) begin
            r_enc_fast <= i_start.fast;
            r_enc_mid  <= i_start.middle;
            r_enc_slow <= i_start.slow;
            r_dec_fast <= i_start.fast;
            r_dec_mid  <= i_start.middle;
            r_dec_slow <= i_start.slow;
        end else if (accept) begin
            if (t_cmd'(i_command) == CMD_DECRYPT) begin
                r_dec_fast <= n_fast;
                r_dec_mid  <= n_mid;
                r_dec_slow <= n_slow;
            end else begin
                r_enc_fast <= n_fast;
                r_enc_mid  <= n_mid;
                r_enc_slow <= n_slow;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/tnc_fifo.sv
// ----------------------------------------------------------------------------
// tnc_fifo
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tnc_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire tnc_pkg::t_job  i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output tnc_pkg::t_job       o_data
);
    import tnc_pkg::*;

    localparam int unsigned PtrW = $clog2(FifoDepth);

    t_job              r_mem [FifoDepth];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PtrW:0]     r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (PtrW+1)'(FifoDepth));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/tnc_back.sv
// ----------------------------------------------------------------------------
// tnc_back
// Two-stage cipher datapath: forward rotor pass and reflector, then the
// inverse rotor searches into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tnc_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire tnc_pkg::t_wiring i_wiring,
    input  wire                   i_job_valid,
    input  wire tnc_pkg::t_job    i_job,
    output logic                  o_job_pop,
    output logic                  o_valid,
    output tnc_pkg::t_nib         o_symbol_out,
    input  wire                   i_ready
);
    import tnc_pkg::*;

    typedef struct packed {
        t_nib r;
        t_nib f;
        t_nib m;
        t_nib s;
    } t_mid;

    logic  r_s1_valid;
    t_mid  r_s1;
    t_mid  n_s1;
    logic  r_out_valid;
    t_nib  r_out;
    t_nib  n_out;
    logic  out_free, s1_free;
    t_nib  a, b, c, ci, bi;

    assign out_free  = !r_out_valid || i_ready;
    assign s1_free   = !r_s1_valid || out_free;
    assign o_job_pop = i_job_valid && s1_free;
    assign o_valid   = r_out_valid;
    assign o_symbol_out = r_out;

    // forward through rotors one to three and the reflector
    always_comb begin
        a = nib_of(i_wiring.rotor_one, i_job.x + i_job.f);
        b = nib_of(i_wiring.rotor_two, a + i_job.m - i_job.f);
        c = nib_of(i_wiring.rotor_three, b + i_job.s - i_job.m);
        n_s1.r = nib_of(i_wiring.reflector, c - i_job.s);
        n_s1.f = i_job.f;
        n_s1.m = i_job.m;
        n_s1.s = i_job.s;
    end

    // back through the inverse searches
    always_comb begin
        ci    = inverse_of(i_wiring.rotor_three, r_s1.r + r_s1.s);
        bi    = inverse_of(i_wiring.rotor_two, ci - r_s1.s + r_s1.m);
        n_out = inverse_of(i_wiring.rotor_one, bi - r_s1.f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_job_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_s1 <= n_s1;
        end
        if (out_free && r_s1_valid) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// File: hdl/three_rotor_nibble_cipher_core.sv
// ----------------------------------------------------------------------------
// three_rotor_nibble_cipher_core
// Enigma-style nibble cipher with three rotors, a reflector and separate
// encrypt and decrypt rotor positions.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_valid/o_ready carries i_command (0 encrypt, 1 decrypt)
//   and i_symbol_in; output channel o_valid/i_ready carries o_symbol_out,
//   one result word per input word, in order.
//   the front steps the rotor positions as a word is taken, a two-entry
//   queue holds the offsets, and the back runs the forward pass and the
//   inverse searches in two register stages.
//   an accepted word passes the queue and the two back stages to o_valid;
//   throughput is one word per cycle with i_ready high, bounded by them.
//   a stalled receiver holds the output register; the back stages and then
//   the queue fill, and o_ready drops once the queue is full.
//   the config port (i_cfg_we, i_cfg_index, i_cfg_data) writes wiring and
//   start registers; any start write reloads all positions.
//   reset loads identity rotors, the default reflector and zero positions.
// ----------------------------------------------------------------------------
`default_nettype none

module three_rotor_nibble_cipher_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [tnc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire [tnc_pkg::CfgDataW-1:0]  i_cfg_data,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_command,
    input  wire [3:0]                    i_symbol_in,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [3:0]                   o_symbol_out
);
    import tnc_pkg::*;

    t_wiring r_wiring;
    t_pos    r_fast_start, r_mid_start, r_slow_start;
    t_start  start;
    logic    job_valid, job_full, job_empty, job_pop;
    t_job    job_in, job_out;

    // start values seen by the front in the same cycle as the write
    always_comb begin
        start.load   = 1'b0;
        start.fast   = r_fast_start;
        start.middle = r_mid_start;
        start.slow   = r_slow_start;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_FAST_START: begin
                    start.load = 1'b1;
                    start.fast = i_cfg_data[PosW-1:0];
                end
                REG_MIDDLE_START: begin
                    start.load   = 1'b1;
                    start.middle = i_cfg_data[PosW-1:0];
                end
                REG_SLOW_START: begin
                    start.load = 1'b1;
                    start.slow = i_cfg_data[PosW-1:0];
                end
                default: start.load = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wiring.rotor_one   <= RotorIdentity;
            r_wiring.rotor_two   <= RotorIdentity;
            r_wiring.rotor_three <= RotorIdentity;
            r_wiring.reflector   <= ReflectorReset;
            r_fast_start <= '0;
            r_mid_start  <= '0;
            r_slow_start <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_ROTOR_ONE:    r_wiring.rotor_one   <= i_cfg_data;
                REG_ROTOR_TWO:    r_wiring.rotor_two   <= i_cfg_data;
                REG_ROTOR_THREE:  r_wiring.rotor_three <= i_cfg_data;
                REG_REFLECTOR:    r_wiring.reflector   <= i_cfg_data;
                REG_FAST_START:   r_fast_start <= i_cfg_data[PosW-1:0];
                REG_MIDDLE_START: r_mid_start  <= i_cfg_data[PosW-1:0];
                REG_SLOW_START:   r_slow_start <= i_cfg_data[PosW-1:0];
                default:          r_fast_start <= r_fast_start;
            endcase
        end
    end

    tnc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_symbol_in (i_symbol_in),
        .o_job_valid (job_valid),
        .o_job       (job_in),
        .i_job_ready (!job_full)
    );

    tnc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    tnc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wiring     (r_wiring),
        .i_job_valid  (!job_empty),
        .i_job        (job_out),
        .o_job_pop    (job_pop),
        .o_valid      (o_valid),
        .o_symbol_out (o_symbol_out),
        .i_ready      (i_ready)
    );

endmodule

`default_nettype wire

// File: dv/tb_three_rotor_nibble_cipher_core.sv
// ----------------------------------------------------------------------------
// tb_three_rotor_nibble_cipher_core
// Self-checking bench for the three-rotor nibble cipher. Every word accepted
// on the input channel is run through a local cipher model that keeps its own
// wiring, start registers and rotor positions. Each result word is compared
// in order against the model. Directed checks cover the reset wiring, rotor
// wrap and carry, degenerate wirings and ignored register writes. Randomized
// traffic with idle and stall mixes and a long receiver hold-off follows.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_three_rotor_nibble_cipher_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tnc_pkg::*;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data  = '0;
    logic                i_valid     = 1'b0;
    logic                i_command   = 1'b0;
    logic [3:0]          i_symbol_in = 4'd0;
    logic                i_ready     = 1'b0;
    wire                 o_ready;
    wire                 o_valid;
    wire [3:0]           o_symbol_out;

    three_rotor_nibble_cipher_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_symbol_in  (i_symbol_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_symbol_out (o_symbol_out)
    );

    // cipher model state
    logic [63:0] rotor_one_w;
    logic [63:0] rotor_two_w;
    logic [63:0] rotor_three_w;
    logic [63:0] reflector_w;
    t_pos        start_fast;
    t_pos        start_middle;
    t_pos        start_slow;
    t_pos        pos_fast   [2];
    t_pos        pos_middle [2];
    t_pos        pos_slow   [2];

    t_nib expected_symbols [$];
    int   error_count       = 0;
    int   sender_idle_pct   = 0;
    int   receiver_idle_pct = 0;
    bit   hold_request      = 1'b0;
    int   hold_count        = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(2_000_000);
        $display("tb_three_rotor_nibble_cipher_core: FAIL");
        $finish;
    end

    function automatic t_nib tap(input logic [63:0] w, input t_nib idx);
        return t_nib'(w >> (idx * 4));
    endfunction

    // first index whose image equals target, zero when none does
    function automatic t_nib tap_search(input logic [63:0] w, input t_nib target);
        int hit;
        hit = -1;
        for (int i = 0; i < 16; i++) begin
            if (hit < 0 && tap(w, t_nib'(i)) == target) begin
                hit = i;
            end
        end
        return (hit < 0) ? t_nib'(0) : t_nib'(hit);
    endfunction

    function automatic void reload_positions();
        for (int d = 0; d < 2; d++) begin
            pos_fast[d]   = start_fast;
            pos_middle[d] = start_middle;
            pos_slow[d]   = start_slow;
        end
    endfunction

    function automatic void reset_cipher_model();
        rotor_one_w   = RotorIdentity;
        rotor_two_w   = RotorIdentity;
        rotor_three_w = RotorIdentity;
        reflector_w   = ReflectorReset;
        start_fast    = '0;
        start_middle  = '0;
        start_slow    = '0;
        reload_positions();
    endfunction

    // steps the selected position set and returns the transformed nibble
    function automatic t_nib cipher_step(input t_cmd cmd, input t_nib sym);
        t_nib f, m, s, a, b, c, r, k;
        int   d;
        d = (cmd == CMD_DECRYPT) ? 1 : 0;
        pos_fast[d]++;
        if (pos_fast[d] == '0) begin
            pos_middle[d]++;
            if (pos_middle[d] == '0) begin
                pos_slow[d]++;
            end
        end
        f = pos_fast[d][3:0];
        m = pos_middle[d][3:0];
        s = pos_slow[d][3:0];
        k = sym + f;
        a = tap(rotor_one_w, k);
        k = a + m - f;
        b = tap(rotor_two_w, k);
        k = b + s - m;
        c = tap(rotor_three_w, k);
        k = c - s;
        r = tap(reflector_w, k);
        k = r + s;
        c = tap_search(rotor_three_w, k);
        k = c - s + m;
        b = tap_search(rotor_two_w, k);
        k = b - f;
        return tap_search(rotor_one_w, k);
    endfunction

    function automatic logic [63:0] random_word64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] random_permutation();
        t_nib        p [16];
        t_nib        t;
        int          j;
        logic [63:0] w;
        for (int i = 0; i < 16; i++) p[i] = t_nib'(i);
        for (int i = 15; i > 0; i--) begin
            j    = $urandom_range(i);
            t    = p[i];
            p[i] = p[j];
            p[j] = t;
        end
        for (int i = 0; i < 16; i++) w[i*4 +: 4] = p[i];
        return w;
    endfunction

    // pairs up a shuffled alphabet so that the wiring is its own inverse
    function automatic logic [63:0] random_involution();
        logic [63:0] shuffled;
        logic [63:0] w;
        t_nib        lo, hi;
        shuffled = random_permutation();
        w        = '0;
        for (int k = 0; k < 16; k += 2) begin
            lo = shuffled[k*4 +: 4];
            hi = shuffled[(k+1)*4 +: 4];
            w[lo*4 +: 4] = hi;
            w[hi*4 +: 4] = lo;
        end
        return w;
    endfunction

    function automatic t_pos pick_start();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return t_pos'(8'hF0 + $urandom_range(15));
            default: return t_pos'($urandom_range(255));
        endcase
    endfunction

    task automatic cfg_write(input t_cfg_idx idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_ROTOR_ONE:    rotor_one_w   = data;
            REG_ROTOR_TWO:    rotor_two_w   = data;
            REG_ROTOR_THREE:  rotor_three_w = data;
            REG_REFLECTOR:    reflector_w   = data;
            REG_FAST_START: begin
                start_fast = data[7:0];
                reload_positions();
            end
            REG_MIDDLE_START: begin
                start_middle = data[7:0];
                reload_positions();
            end
            REG_SLOW_START: begin
                start_slow = data[7:0];
                reload_positions();
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_word(input t_cmd cmd, input t_nib sym);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_symbol_in <= sym;
        expected_symbols.push_back(cipher_step(cmd, sym));
        do @(posedge i_clk); while (!o_ready);
    endtask

    // stop offering words and let every expected result come out
    task automatic settle_block();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_symbols.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic randomize_config();
        cfg_write(REG_ROTOR_ONE,   ($urandom_range(9) == 0) ? random_word64() : random_permutation());
        cfg_write(REG_ROTOR_TWO,   ($urandom_range(9) == 0) ? random_word64() : random_permutation());
        cfg_write(REG_ROTOR_THREE, ($urandom_range(9) == 0) ? random_word64() : random_permutation());
        cfg_write(REG_REFLECTOR,   ($urandom_range(9) == 0) ? random_word64() : random_involution());
        cfg_write(REG_FAST_START,   (random_word64() << 8) | 64'(pick_start()));
        cfg_write(REG_MIDDLE_START, (random_word64() << 8) | 64'(pick_start()));
        cfg_write(REG_SLOW_START,   (random_word64() << 8) | 64'(pick_start()));
    endtask

    task automatic test_reset_defaults();
        send_word(CMD_ENCRYPT, 4'h0);
        send_word(CMD_ENCRYPT, 4'hF);
        send_word(CMD_DECRYPT, 4'h0);
        send_word(CMD_DECRYPT, 4'hF);
        send_word(CMD_ENCRYPT, 4'h5);
        send_word(CMD_DECRYPT, 4'hA);
        settle_block();
    endtask

    // all three positions at 255 so the first step carries through every rotor
    task automatic test_position_wrap();
        cfg_write(REG_FAST_START,   64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_MIDDLE_START, 64'h0000_0000_0000_00FF);
        cfg_write(REG_SLOW_START,   64'h0000_0000_0000_00FF);
        send_word(CMD_ENCRYPT, 4'h3);
        send_word(CMD_DECRYPT, 4'hC);
        send_word(CMD_ENCRYPT, 4'h0);
        settle_block();
        cfg_write(REG_MIDDLE_START, 64'h0000_0000_0000_0000);
        send_word(CMD_DECRYPT, 4'hF);
        send_word(CMD_DECRYPT, 4'h7);
        settle_block();
    endtask

    // non-permutation wirings exercise the no-match and lowest-match searches
    task automatic test_degenerate_wiring();
        cfg_write(REG_ROTOR_ONE, 64'h0000_0000_0000_0000);
        cfg_write(REG_ROTOR_TWO, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(CMD_ENCRYPT, 4'h9);
        send_word(CMD_DECRYPT, 4'h1);
        settle_block();
        cfg_write(REG_ROTOR_THREE, random_word64());
        cfg_write(REG_REFLECTOR,   random_word64());
        send_word(CMD_ENCRYPT, 4'hE);
        send_word(CMD_DECRYPT, 4'h2);
        settle_block();
        cfg_write(REG_ROTOR_ONE, random_word64());
        cfg_write(REG_ROTOR_TWO, random_permutation());
        send_word(CMD_ENCRYPT, 4'h6);
        send_word(CMD_ENCRYPT, 4'hB);
        settle_block();
    endtask

    // a wiring write must not reload the positions
    task automatic test_rotor_write_keeps_positions();
        cfg_write(REG_FAST_START, 64'h0000_0000_0000_00FE);
        send_word(CMD_ENCRYPT, 4'h4);
        send_word(CMD_DECRYPT, 4'h8);
        settle_block();
        cfg_write(REG_ROTOR_ONE, random_permutation());
        cfg_write(REG_REFLECTOR, random_involution());
        send_word(CMD_ENCRYPT, 4'hD);
        send_word(CMD_DECRYPT, 4'h0);
        settle_block();
    endtask

    task automatic test_unused_index();
        cfg_write(REG_UNUSED, random_word64());
        send_word(CMD_ENCRYPT, 4'hF);
        send_word(CMD_DECRYPT, 4'h5);
        settle_block();
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_words);
        t_cmd cmd;
        int   run_left;
        run_left          = 0;
        cmd               = CMD_ENCRYPT;
        sender_idle_pct   = snd_pct;
        receiver_idle_pct = rcv_pct;
        randomize_config();
        for (int i = 0; i < n_words; i++) begin
            if (i == n_words / 2) begin
                settle_block();
                randomize_config();
            end
            // runs of one direction push the positions through their carries
            if (run_left == 0) begin
                cmd      = t_cmd'($urandom_range(1));
                run_left = $urandom_range(1, 20);
            end
            run_left--;
            send_word(cmd, t_nib'($urandom_range(15)));
        end
        settle_block();
    endtask

    task automatic test_receiver_hold_off();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        randomize_config();
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_word(t_cmd'($urandom_range(1)), t_nib'($urandom_range(15)));
        end
        settle_block();
    endtask

    // receiver side, including the long hold-off
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_count   = 300;
        end
        if (hold_count > 0) begin
            i_ready <= 1'b0;
            hold_count--;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_symbols.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %h",
                         $time, o_symbol_out);
                error_count++;
            end else begin
                t_nib want;
                want = expected_symbols.pop_front();
                if (o_symbol_out !== want) begin
                    $display("%0t: symbol_out mismatch: expected %h, actual %h",
                             $time, want, o_symbol_out);
                    error_count++;
                end
            end
        end
    end

    initial begin
        reset_cipher_model();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_position_wrap();
        test_degenerate_wiring();
        test_rotor_write_keeps_positions();
        test_unused_index();
        test_random_traffic(23, 60, 125);
        test_random_traffic(60, 23, 125);
        test_random_traffic(0, 0, 125);
        test_receiver_hold_off();

        settle_block();
        if (error_count == 0) begin
            $display("tb_three_rotor_nibble_cipher_core: PASS");
        end else begin
            $display("tb_three_rotor_nibble_cipher_core: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
